// ===== rtl/hebs_pkg.sv =====
// Package for the hourly energy balance statistics block.
// Field widths, default parameters, sequencer states and shared types.
// No dependencies.
package hebs_pkg;

   // default table size and sample width
   localparam int SLOTS_DEF       = 24;
   localparam int SAMPLE_BITS_DEF = 16;

   // result field widths
   localparam int WH_BITS    = 21;
   localparam int W_BITS     = 16;
   localparam int HOUR_BITS  = 5;
   localparam int RATIO_BITS = 10;

   localparam int                   PERMILLE = 1000;
   localparam logic [HOUR_BITS-1:0] NO_HOUR  = 5'd31;

   // input kind codes
   localparam logic KIND_RECORD = 1'b0;
   localparam logic KIND_QUERY  = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_FLUSH,
      ST_START,
      ST_DIV,
      ST_LOAD
   } hebs_state_type;

   // accumulator control from the sequencer
   typedef struct packed {
      logic clear;
      logic beat;
   } hebs_acc_ctl_type;

endpackage

// ===== rtl/hebs_store.sv =====
// Sample store: two SLOTS-deep sample memories with per-slot valid bits.
// Unwritten slots read as zero. No dependencies.
module hebs_store #(
   parameter int SLOTS       = 24,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       wr_en,
   input  logic [$clog2(SLOTS)-1:0]   wr_addr,
   input  logic [SAMPLE_BITS-1:0]     wr_prod,
   input  logic [SAMPLE_BITS-1:0]     wr_conso,
   input  logic [$clog2(SLOTS)-1:0]   rd_addr,
   output logic [SAMPLE_BITS-1:0]     rd_prod,
   output logic [SAMPLE_BITS-1:0]     rd_conso
);

   logic [SAMPLE_BITS-1:0] prod_mem  [SLOTS];
   logic [SAMPLE_BITS-1:0] conso_mem [SLOTS];
   logic [SLOTS-1:0]       vld_ff;
   logic [SLOTS-1:0]       vld_in;
   logic [SAMPLE_BITS-1:0] rd_prod_ff;
   logic [SAMPLE_BITS-1:0] rd_conso_ff;
   logic                   rd_vld_ff;

   always_comb begin
      vld_in = vld_ff;
      if (wr_en) begin
         vld_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         prod_mem[wr_addr]  <= wr_prod;
         conso_mem[wr_addr] <= wr_conso;
      end
      rd_prod_ff  <= prod_mem[rd_addr];
      rd_conso_ff <= conso_mem[rd_addr];
      rd_vld_ff   <= vld_ff[rd_addr];
   end

   assign rd_prod  = rd_vld_ff ? rd_prod_ff  : '0;
   assign rd_conso = rd_vld_ff ? rd_conso_ff : '0;

endmodule

// ===== rtl/hebs_accum.sv =====
// Walk accumulator: sums, self-used and surplus sums, and first-peak tracking.
// Takes one slot per beat. Depends on hebs_pkg.
module hebs_accum #(
   parameter int SLOTS       = 24,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                    clock,
   input  hebs_pkg::hebs_acc_ctl_type              ctl,
   input  logic [$clog2(SLOTS)-1:0]                slot,
   input  logic [SAMPLE_BITS-1:0]                  prod,
   input  logic [SAMPLE_BITS-1:0]                  conso,
   output logic [SAMPLE_BITS+$clog2(SLOTS)-1:0]    tp_sum,
   output logic [SAMPLE_BITS+$clog2(SLOTS)-1:0]    tc_sum,
   output logic [SAMPLE_BITS+$clog2(SLOTS)-1:0]    self_sum,
   output logic [SAMPLE_BITS+$clog2(SLOTS)-1:0]    inj_sum,
   output logic [SAMPLE_BITS-1:0]                  pk_prod,
   output logic [$clog2(SLOTS)-1:0]                pk_prod_slot,
   output logic [SAMPLE_BITS-1:0]                  pk_conso,
   output logic [$clog2(SLOTS)-1:0]                pk_conso_slot
);

   localparam int IDX_W = $clog2(SLOTS);
   localparam int SUM_W = SAMPLE_BITS + IDX_W;

   logic [SUM_W-1:0]       tp_ff, tp_in, tc_ff, tc_in;
   logic [SUM_W-1:0]       self_ff, self_in, inj_ff, inj_in;
   logic [SAMPLE_BITS-1:0] pkp_ff, pkp_in, pkc_ff, pkc_in;
   logic [IDX_W-1:0]       hrp_ff, hrp_in, hrc_ff, hrc_in;
   logic [SAMPLE_BITS-1:0] low_w;
   logic [SAMPLE_BITS-1:0] surplus_w;

   always_comb begin
      low_w     = (prod < conso) ? prod : conso;
      surplus_w = (prod > conso) ? (prod - conso) : '0;
      tp_in   = tp_ff;
      tc_in   = tc_ff;
      self_in = self_ff;
      inj_in  = inj_ff;
      pkp_in  = pkp_ff;
      pkc_in  = pkc_ff;
      hrp_in  = hrp_ff;
      hrc_in  = hrc_ff;
      if (ctl.clear) begin
         tp_in   = '0;
         tc_in   = '0;
         self_in = '0;
         inj_in  = '0;
         pkp_in  = '0;
         pkc_in  = '0;
         hrp_in  = '0;
         hrc_in  = '0;
      end else if (ctl.beat) begin
         tp_in   = tp_ff + SUM_W'(prod);
         tc_in   = tc_ff + SUM_W'(conso);
         self_in = self_ff + SUM_W'(low_w);
         inj_in  = inj_ff + SUM_W'(surplus_w);
         // strict compare keeps the first hour of a tie
         if (prod > pkp_ff) begin
            pkp_in = prod;
            hrp_in = slot;
         end
         if (conso > pkc_ff) begin
            pkc_in = conso;
            hrc_in = slot;
         end
      end
   end

   always_ff @(posedge clock) begin
      tp_ff   <= tp_in;
      tc_ff   <= tc_in;
      self_ff <= self_in;
      inj_ff  <= inj_in;
      pkp_ff  <= pkp_in;
      pkc_ff  <= pkc_in;
      hrp_ff  <= hrp_in;
      hrc_ff  <= hrc_in;
   end

   assign tp_sum        = tp_ff;
   assign tc_sum        = tc_ff;
   assign self_sum      = self_ff;
   assign inj_sum       = inj_ff;
   assign pk_prod       = pkp_ff;
   assign pk_prod_slot  = hrp_ff;
   assign pk_conso      = pkc_ff;
   assign pk_conso_slot = hrc_ff;

endmodule

// ===== rtl/hebs_div.sv =====
// Ratio unit: floor(self * 1000 / total) by restoring division, one bit a cycle.
// Quotient never exceeds 1000 since self <= total. Depends on hebs_pkg.
module hebs_div #(
   parameter int SUM_W = 21
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [SUM_W-1:0]                num,
   input  logic [SUM_W-1:0]                den,
   output logic                            done,
   output logic [hebs_pkg::RATIO_BITS-1:0] quot
);

   localparam int RB    = hebs_pkg::RATIO_BITS;
   localparam int NUM_W = SUM_W + RB;
   localparam int CNT_W = $clog2(RB);

   logic [NUM_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] dv_ff, dv_in;
   logic [RB-1:0]    q_ff, q_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic             zero_ff, zero_in;
   logic [NUM_W-1:0] num_x;

   always_comb begin
      num_x   = NUM_W'(num);
      rem_in  = rem_ff;
      dv_in   = dv_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      zero_in = zero_ff;
      if (start) begin
         // times 1000 = 1024 - 16 - 8
         rem_in  = (num_x << 10) - (num_x << 4) - (num_x << 3);
         dv_in   = NUM_W'(den) << (RB - 1);
         q_in    = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
         zero_in = (den == '0);
      end else if (busy_ff) begin
         if (rem_ff >= dv_ff) begin
            rem_in = rem_ff - dv_ff;
            q_in   = {q_ff[RB-2:0], 1'b1};
         end else begin
            q_in   = {q_ff[RB-2:0], 1'b0};
         end
         dv_in  = dv_ff >> 1;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(RB - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dv_ff   <= dv_in;
      q_ff    <= q_in;
      cnt_ff  <= cnt_in;
      zero_ff <= zero_in;
   end

   assign done = done_ff;
   assign quot = zero_ff ? '0 : q_ff;

endmodule

// ===== rtl/hourly_energy_balance_stats.sv =====
// Hourly energy balance statistics, top level.
// Depends on hebs_pkg, hebs_store, hebs_accum and hebs_div.
//
// Usage:
//  - req_ channel carries one item per transfer. A record item (kind 0) stores
//    prod_w/conso_w in the slot of its hour, unless the hour is out of range or
//    equals the last recorded hour. It gives no result.
//  - A query item (kind 1) walks all SLOTS slots through the stored samples,
//    one slot a cycle, then runs a 10-step restoring division for the
//    self-consumption ratio. Its result is then loaded into the output
//    register and raised on rsp_valid; req_ready is low meanwhile.
//  - Sums and peaks are returned in watt-hours and watts; kWh scaling is left
//    to software. The ratio is 0 when total production is 0.
//  - A finished result sits in an output register until rsp_ready takes it;
//    records are still taken meanwhile. A second query finishes its work and
//    then waits for the output register to free up.
//  - Reset (synchronous, active high) empties the table (every slot reads
//    zero) and forgets the last recorded hour; it takes effect at once.
module hourly_energy_balance_stats #(
   parameter int SLOTS       = hebs_pkg::SLOTS_DEF,
   parameter int SAMPLE_BITS = hebs_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_kind,
   input  logic [4:0]                             req_hour,
   input  logic [15:0]                            req_prod_w,
   input  logic [15:0]                            req_conso_w,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [hebs_pkg::WH_BITS-1:0]           rsp_total_prod_wh,
   output logic [hebs_pkg::WH_BITS-1:0]           rsp_total_conso_wh,
   output logic [hebs_pkg::WH_BITS-1:0]           rsp_self_used_wh,
   output logic [hebs_pkg::WH_BITS-1:0]           rsp_injected_wh,
   output logic [hebs_pkg::W_BITS-1:0]            rsp_peak_prod_w,
   output logic [hebs_pkg::HOUR_BITS-1:0]         rsp_peak_prod_hour,
   output logic [hebs_pkg::W_BITS-1:0]            rsp_peak_conso_w,
   output logic [hebs_pkg::HOUR_BITS-1:0]         rsp_peak_conso_hour,
   output logic [hebs_pkg::RATIO_BITS-1:0]        rsp_self_ratio_permille
);

   localparam int IDX_W = $clog2(SLOTS);
   localparam int SUM_W = SAMPLE_BITS + IDX_W;
   localparam logic [6:0] SLOTS_L = 7'(SLOTS);

   hebs_pkg::hebs_state_type state_ff, state_in;

   logic [IDX_W-1:0]                    idx_ff, idx_in;
   logic                                beat_ff;
   logic [IDX_W-1:0]                    beat_idx_ff;
   logic [hebs_pkg::HOUR_BITS-1:0]      last_hour_ff, last_hour_in;
   logic                                rsp_valid_ff, rsp_valid_in;

   logic                                accept;
   logic                                rec_ok;
   logic                                wr_en;
   logic                                slot_free;
   logic                                load_out;
   logic                                div_start;
   logic                                div_done;
   hebs_pkg::hebs_acc_ctl_type          acc_ctl;

   logic [SAMPLE_BITS-1:0]              rd_prod, rd_conso;
   logic [SUM_W-1:0]                    tp_sum, tc_sum, self_sum, inj_sum;
   logic [SAMPLE_BITS-1:0]              pk_prod, pk_conso;
   logic [IDX_W-1:0]                    pk_prod_slot, pk_conso_slot;
   logic [hebs_pkg::RATIO_BITS-1:0]     quot;

   // output register
   logic [hebs_pkg::WH_BITS-1:0]        o_tp_ff, o_tc_ff, o_self_ff, o_inj_ff;
   logic [hebs_pkg::W_BITS-1:0]         o_pkp_ff, o_pkc_ff;
   logic [hebs_pkg::HOUR_BITS-1:0]      o_hrp_ff, o_hrc_ff;
   logic [hebs_pkg::RATIO_BITS-1:0]     o_ratio_ff;

   assign accept    = req_valid & req_ready;
   assign slot_free = ~rsp_valid_ff | rsp_ready;

   // a record lands only for an in-range hour that differs from the last one
   assign rec_ok = ({2'b00, req_hour} < SLOTS_L) && (req_hour != last_hour_ff);
   assign wr_en  = accept && (req_kind == hebs_pkg::KIND_RECORD) && rec_ok;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         hebs_pkg::ST_IDLE: begin
            if (accept && (req_kind == hebs_pkg::KIND_QUERY)) begin
               state_in = hebs_pkg::ST_WALK;
            end
         end
         hebs_pkg::ST_WALK: begin
            if (idx_ff == IDX_W'(SLOTS - 1)) begin
               state_in = hebs_pkg::ST_FLUSH;
            end
         end
         hebs_pkg::ST_FLUSH: state_in = hebs_pkg::ST_START;
         hebs_pkg::ST_START: state_in = hebs_pkg::ST_DIV;
         hebs_pkg::ST_DIV: begin
            if (div_done) begin
               state_in = hebs_pkg::ST_LOAD;
            end
         end
         hebs_pkg::ST_LOAD: begin
            if (slot_free) begin
               state_in = hebs_pkg::ST_IDLE;
            end
         end
         default: state_in = hebs_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready     = 1'b0;
      acc_ctl.clear = 1'b0;
      div_start     = 1'b0;
      load_out      = 1'b0;
      unique case (state_ff)
         hebs_pkg::ST_IDLE: begin
            req_ready     = 1'b1;
            acc_ctl.clear = req_valid && (req_kind == hebs_pkg::KIND_QUERY);
         end
         hebs_pkg::ST_START: div_start = 1'b1;
         hebs_pkg::ST_LOAD:  load_out  = slot_free;
         default: ;
      endcase
      acc_ctl.beat = beat_ff;
   end

   always_comb begin
      idx_in = '0;
      if (state_ff == hebs_pkg::ST_WALK) begin
         idx_in = idx_ff + 1'b1;
      end
      last_hour_in = wr_en ? req_hour : last_hour_ff;
      rsp_valid_in = load_out | (rsp_valid_ff & ~rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hebs_pkg::ST_IDLE;
         idx_ff       <= '0;
         beat_ff      <= 1'b0;
         last_hour_ff <= hebs_pkg::NO_HOUR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         beat_ff      <= (state_ff == hebs_pkg::ST_WALK);
         last_hour_ff <= last_hour_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // slot number travels with the registered read
   always_ff @(posedge clock) begin
      beat_idx_ff <= idx_ff;
   end

   hebs_store #(
      .SLOTS       (SLOTS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (wr_en),
      .wr_addr  (IDX_W'(req_hour)),
      .wr_prod  (SAMPLE_BITS'(req_prod_w)),
      .wr_conso (SAMPLE_BITS'(req_conso_w)),
      .rd_addr  (idx_ff),
      .rd_prod  (rd_prod),
      .rd_conso (rd_conso)
   );

   hebs_accum #(
      .SLOTS       (SLOTS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_accum (
      .clock         (clock),
      .ctl           (acc_ctl),
      .slot          (beat_idx_ff),
      .prod          (rd_prod),
      .conso         (rd_conso),
      .tp_sum        (tp_sum),
      .tc_sum        (tc_sum),
      .self_sum      (self_sum),
      .inj_sum       (inj_sum),
      .pk_prod       (pk_prod),
      .pk_prod_slot  (pk_prod_slot),
      .pk_conso      (pk_conso),
      .pk_conso_slot (pk_conso_slot)
   );

   hebs_div #(
      .SUM_W (SUM_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (self_sum),
      .den   (tp_sum),
      .done  (div_done),
      .quot  (quot)
   );

   // result register; sums wrap to the field width
   always_ff @(posedge clock) begin
      if (load_out) begin
         o_tp_ff    <= hebs_pkg::WH_BITS'(tp_sum);
         o_tc_ff    <= hebs_pkg::WH_BITS'(tc_sum);
         o_self_ff  <= hebs_pkg::WH_BITS'(self_sum);
         o_inj_ff   <= hebs_pkg::WH_BITS'(inj_sum);
         o_pkp_ff   <= hebs_pkg::W_BITS'(pk_prod);
         o_hrp_ff   <= hebs_pkg::HOUR_BITS'(pk_prod_slot);
         o_pkc_ff   <= hebs_pkg::W_BITS'(pk_conso);
         o_hrc_ff   <= hebs_pkg::HOUR_BITS'(pk_conso_slot);
         o_ratio_ff <= quot;
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_total_prod_wh       = o_tp_ff;
   assign rsp_total_conso_wh      = o_tc_ff;
   assign rsp_self_used_wh        = o_self_ff;
   assign rsp_injected_wh         = o_inj_ff;
   assign rsp_peak_prod_w         = o_pkp_ff;
   assign rsp_peak_prod_hour      = o_hrp_ff;
   assign rsp_peak_conso_w        = o_pkc_ff;
   assign rsp_peak_conso_hour     = o_hrc_ff;
   assign rsp_self_ratio_permille = o_ratio_ff;

`ifndef SYNTHESIS
   a_ratio_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_self_ratio_permille <= 10'(hebs_pkg::PERMILLE)))
      else $error("ratio above 1000 permille");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == hebs_pkg::ST_DIV))
      else $error("divider finished outside of the divide state");

   a_last_hour: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> (last_hour_ff == $past(req_hour)))
      else $error("last hour not updated by a stored record");

   a_no_load_over_pending: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !load_out)
      else $error("result overwritten before transfer");
`endif

endmodule

// ===== dv/hourly_energy_balance_stats_tb.sv =====
// Testbench for hourly_energy_balance_stats: directed table then random record/query traffic.
// Uses hebs_pkg widths and kind codes; predicts from its own hourly table or typed-in rows.
// Standalone, no files or arguments.
module hourly_energy_balance_stats_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int N_SLOTS          = hebs_pkg::SLOTS_DEF;
   localparam int WH_BITS          = hebs_pkg::WH_BITS;
   localparam int W_BITS           = hebs_pkg::W_BITS;
   localparam int HOUR_BITS        = hebs_pkg::HOUR_BITS;
   localparam int RATIO_BITS       = hebs_pkg::RATIO_BITS;
   localparam int ITEM_TARGET      = 1950;  // records that land plus queries
   localparam int TAIL_ITEMS       = 150;   // final stretch runs with no idling
   localparam int LONG_HOLD_AT     = 700;
   localparam int MID_PAUSE_AT     = 1200;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES     = 2 * (N_SLOTS + 14);

   // content profiles for a day of samples
   typedef enum int {
      PROF_FULL,
      PROF_ZERO,
      PROF_LOW,
      PROF_ANY,
      PROF_SELF_ONLY   // production never above consumption in the hours the run writes
   } watt_profile_type;

   typedef struct packed {
      logic [WH_BITS-1:0]    total_prod_wh;
      logic [WH_BITS-1:0]    total_conso_wh;
      logic [WH_BITS-1:0]    self_used_wh;
      logic [WH_BITS-1:0]    injected_wh;
      logic [W_BITS-1:0]     peak_prod_w;
      logic [HOUR_BITS-1:0]  peak_prod_hour;
      logic [W_BITS-1:0]     peak_conso_w;
      logic [HOUR_BITS-1:0]  peak_conso_hour;
      logic [RATIO_BITS-1:0] self_ratio_permille;
   } day_summary_type;

   // one row of the directed table; known rows carry the summary typed in
   typedef struct {
      logic            kind;
      logic [4:0]      hour;
      logic [15:0]     prod;
      logic [15:0]     conso;
      bit              known;
      day_summary_type summ;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_valid   = 1'b0;
   logic        req_ready;
   logic        req_kind    = hebs_pkg::KIND_RECORD;
   logic [4:0]  req_hour    = '0;
   logic [15:0] req_prod_w  = '0;
   logic [15:0] req_conso_w = '0;

   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [WH_BITS-1:0]    rsp_total_prod_wh;
   logic [WH_BITS-1:0]    rsp_total_conso_wh;
   logic [WH_BITS-1:0]    rsp_self_used_wh;
   logic [WH_BITS-1:0]    rsp_injected_wh;
   logic [W_BITS-1:0]     rsp_peak_prod_w;
   logic [HOUR_BITS-1:0]  rsp_peak_prod_hour;
   logic [W_BITS-1:0]     rsp_peak_conso_w;
   logic [HOUR_BITS-1:0]  rsp_peak_conso_hour;
   logic [RATIO_BITS-1:0] rsp_self_ratio_permille;

   // predictor state: our own copy of the hourly table
   logic [15:0] prod_table  [N_SLOTS];
   logic [15:0] conso_table [N_SLOTS];
   logic [4:0]  last_rec_hour;

   day_summary_type pending_summaries[$];  // summaries owed by the block, oldest first
   stim_row_type    directed_rows[$];
   stim_row_type    directed_queries[$];   // directed query rows, in order of transfer

   int error_count = 0;
   int n_records   = 0;
   int n_dropped   = 0;
   int n_queries   = 0;
   int n_checked   = 0;

   // idling knobs
   int   req_idle_pct   = 0;
   logic quiet_tail     = 1'b0;
   logic long_hold_req  = 1'b0;
   bit   long_hold_done = 1'b0;

   always #2 clock = ~clock;

   hourly_energy_balance_stats dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_kind               (req_kind),
      .req_hour               (req_hour),
      .req_prod_w             (req_prod_w),
      .req_conso_w            (req_conso_w),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_total_prod_wh      (rsp_total_prod_wh),
      .rsp_total_conso_wh     (rsp_total_conso_wh),
      .rsp_self_used_wh       (rsp_self_used_wh),
      .rsp_injected_wh        (rsp_injected_wh),
      .rsp_peak_prod_w        (rsp_peak_prod_w),
      .rsp_peak_prod_hour     (rsp_peak_prod_hour),
      .rsp_peak_conso_w       (rsp_peak_conso_w),
      .rsp_peak_conso_hour    (rsp_peak_conso_hour),
      .rsp_self_ratio_permille(rsp_self_ratio_permille)
   );

   // ---------------------------------------------------------------- predictor

   // Store a sample pair unless the hour is off the table or repeats the last
   // stored hour. Returns 0 when the record is dropped.
   function automatic bit store_sample(logic [4:0] h, logic [15:0] p, logic [15:0] c);
      if (h >= N_SLOTS || h == last_rec_hour) begin
         return 1'b0;
      end
      last_rec_hour  = h;
      prod_table[h]  = p;
      conso_table[h] = c;
      return 1'b1;
   endfunction

   // Walk the table: totals, self-used (per-hour min), injected (positive
   // surplus), first-hour peaks, and the permille ratio.
   function automatic day_summary_type tally_day();
      day_summary_type s;
      longint unsigned tp, tc, su, inj, ratio;
      logic [15:0]     pk_p, pk_c;
      logic [4:0]      hr_p, hr_c;
      tp   = 0;
      tc   = 0;
      su   = 0;
      inj  = 0;
      pk_p = '0;
      pk_c = '0;
      hr_p = '0;
      hr_c = '0;
      for (int i = 0; i < N_SLOTS; i++) begin
         tp += prod_table[i];
         tc += conso_table[i];
         su += (prod_table[i] < conso_table[i]) ? prod_table[i] : conso_table[i];
         if (prod_table[i] > conso_table[i]) begin
            inj += longint'(prod_table[i]) - longint'(conso_table[i]);
         end
         // strict compare keeps the first hour on ties
         if (prod_table[i] > pk_p) begin
            pk_p = prod_table[i];
            hr_p = 5'(i);
         end
         if (conso_table[i] > pk_c) begin
            pk_c = conso_table[i];
            hr_c = 5'(i);
         end
      end
      ratio = (tp != 0) ? (su * hebs_pkg::PERMILLE) / tp : 0;
      s.total_prod_wh       = tp[WH_BITS-1:0];
      s.total_conso_wh      = tc[WH_BITS-1:0];
      s.self_used_wh        = su[WH_BITS-1:0];
      s.injected_wh         = inj[WH_BITS-1:0];
      s.peak_prod_w         = pk_p;
      s.peak_prod_hour      = hr_p;
      s.peak_conso_w        = pk_c;
      s.peak_conso_hour     = hr_c;
      s.self_ratio_permille = ratio[RATIO_BITS-1:0];
      return s;
   endfunction

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   // ---------------------------------------------------------------- monitor
   // Both channels sampled at the rising edge; drivers only change on NBAs.
   always @(posedge clock) begin
      day_summary_type want;
      stim_row_type    row;
      if (reset) begin
         // table cleared, no hour recorded yet
         for (int i = 0; i < N_SLOTS; i++) begin
            prod_table[i]  = '0;
            conso_table[i] = '0;
         end
         last_rec_hour = hebs_pkg::NO_HOUR;
      end else begin
         // result side first: a summary can never belong to a query taken this edge
         if (rsp_valid && rsp_ready) begin
            if (pending_summaries.size() == 0) begin
               $error("summary transfer with no query outstanding");
               error_count++;
            end else begin
               want = pending_summaries.pop_front();
               n_checked++;
               check_field("total_prod_wh", want.total_prod_wh, rsp_total_prod_wh);
               check_field("total_conso_wh", want.total_conso_wh, rsp_total_conso_wh);
               check_field("self_used_wh", want.self_used_wh, rsp_self_used_wh);
               check_field("injected_wh", want.injected_wh, rsp_injected_wh);
               check_field("peak_prod_w", want.peak_prod_w, rsp_peak_prod_w);
               check_field("peak_prod_hour", want.peak_prod_hour, rsp_peak_prod_hour);
               check_field("peak_conso_w", want.peak_conso_w, rsp_peak_conso_w);
               check_field("peak_conso_hour", want.peak_conso_hour, rsp_peak_conso_hour);
               check_field("self_ratio_permille", want.self_ratio_permille,
                           rsp_self_ratio_permille);
            end
         end
         if (req_valid && req_ready) begin
            if (req_kind == hebs_pkg::KIND_RECORD) begin
               n_records++;
               if (!store_sample(req_hour, req_prod_w, req_conso_w)) begin
                  n_dropped++;
               end
            end else begin
               n_queries++;
               want = tally_day();
               // directed queries come first; a typed-in summary overrides the walk
               if (directed_queries.size() != 0) begin
                  row = directed_queries.pop_front();
                  if (row.known) begin
                     want = row.summ;
                  end
               end
               pending_summaries.push_back(want);
            end
         end
      end
   end

   // ---------------------------------------------------------------- receiver
   // Random stalls in bursts, one long hold-off on request, none in the tail.
   initial begin
      int spins;
      int rsp_idle_pct;
      spins        = 0;
      rsp_idle_pct = 10;
      wait (!reset);
      @(posedge clock);
      forever begin
         spins++;
         if (spins % 200 == 0) begin
            case ($urandom_range(0, 2))
               0:       rsp_idle_pct = 0;
               1:       rsp_idle_pct = 10;
               default: rsp_idle_pct = 35;
            endcase
         end
         if (long_hold_req && !long_hold_done) begin
            // block fills: output register busy, next query waits, req_ready drops
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            long_hold_done = 1'b1;
         end else if (!quiet_tail && rsp_idle_pct != 0 &&
                      $urandom_range(0, 99) < rsp_idle_pct) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // ---------------------------------------------------------------- sender

   // Offer one item and hold it until the transfer; maybe idle afterwards.
   task automatic send_item(logic kind, logic [4:0] h, logic [15:0] p, logic [15:0] c);
      req_valid   <= 1'b1;
      req_kind    <= kind;
      req_hour    <= h;
      req_prod_w  <= p;
      req_conso_w <= c;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (!quiet_tail && req_idle_pct != 0 && $urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
   endtask

   // Stop offering until every owed summary has been taken.
   task automatic hold_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_summaries.size() != 0) @(posedge clock);
   endtask

   task automatic send_query();
      send_item(hebs_pkg::KIND_QUERY, 5'($urandom), 16'($urandom), 16'($urandom));
   endtask

   function automatic logic [15:0] draw_watts(watt_profile_type prof);
      case (prof)
         PROF_FULL: return 16'hFFFF;
         PROF_ZERO: return 16'h0000;
         PROF_LOW:  return 16'($urandom_range(0, 2000));
         default:   return 16'($urandom);
      endcase
   endfunction

   // A run of consecutive hours (wrapping) with one content profile, then a query or two.
   task automatic run_day();
      int               first, len;
      watt_profile_type prof;
      logic [4:0]       h;
      logic [15:0]      p, c;
      first = $urandom_range(0, N_SLOTS - 1);
      len   = $urandom_range(1, N_SLOTS);
      prof  = watt_profile_type'($urandom_range(PROF_FULL, PROF_SELF_ONLY));
      for (int k = 0; k < len; k++) begin
         h = 5'((first + k) % N_SLOTS);
         p = draw_watts(prof);
         c = draw_watts(prof);
         if (prof == PROF_SELF_ONLY) begin
            c = (p > 16'hFFFF - 16'd500) ? 16'hFFFF : p + 16'($urandom_range(0, 500));
         end
         send_item(hebs_pkg::KIND_RECORD, h, p, c);
      end
      send_query();
      if ($urandom_range(0, 3) == 0) begin
         send_query();  // back-to-back queries on an unchanged table
      end
   endtask

   function automatic day_summary_type make_summary(
      int tp, int tc, int su, int inj, int pk_p, int hr_p, int pk_c, int hr_c, int ratio);
      day_summary_type s;
      s.total_prod_wh       = WH_BITS'(tp);
      s.total_conso_wh      = WH_BITS'(tc);
      s.self_used_wh        = WH_BITS'(su);
      s.injected_wh         = WH_BITS'(inj);
      s.peak_prod_w         = W_BITS'(pk_p);
      s.peak_prod_hour      = HOUR_BITS'(hr_p);
      s.peak_conso_w        = W_BITS'(pk_c);
      s.peak_conso_hour     = HOUR_BITS'(hr_c);
      s.self_ratio_permille = RATIO_BITS'(ratio);
      return s;
   endfunction

   function automatic void add_row(logic kind, int h, int p, int c, bit known,
                                   day_summary_type summ);
      stim_row_type r;
      r.kind  = kind;
      r.hour  = 5'(h);
      r.prod  = 16'(p);
      r.conso = 16'(c);
      r.known = known;
      r.summ  = summ;
      directed_rows.push_back(r);
   endfunction

   // Directed table. Known summaries are worked out by hand from the rows above.
   function automatic void build_directed();
      day_summary_type none;
      none = '0;
      // empty table straight after reset
      add_row(hebs_pkg::KIND_QUERY,  0, 0, 0, 1'b1,
              make_summary(0, 0, 0, 0, 0, 0, 0, 0, 0));
      // hour 31: off the table, and also equal to the reset value of last hour
      add_row(hebs_pkg::KIND_RECORD, 31, 16'hFFFF, 16'hFFFF, 1'b0, none);
      add_row(hebs_pkg::KIND_RECORD, 24, 1, 1, 1'b0, none);
      add_row(hebs_pkg::KIND_QUERY,  0, 0, 0, 1'b1,
              make_summary(0, 0, 0, 0, 0, 0, 0, 0, 0));
      // full production, no consumption
      add_row(hebs_pkg::KIND_RECORD, 0, 65535, 0, 1'b0, none);
      add_row(hebs_pkg::KIND_RECORD, 0, 7, 7, 1'b0, none);  // same hour again, dropped
      add_row(hebs_pkg::KIND_QUERY,  0, 0, 0, 1'b1,
              make_summary(65535, 0, 0, 65535, 65535, 0, 0, 0, 0));
      add_row(hebs_pkg::KIND_RECORD, 23, 0, 65535, 1'b0, none);
      add_row(hebs_pkg::KIND_QUERY,  0, 0, 0, 1'b1,
              make_summary(65535, 65535, 0, 65535, 65535, 0, 65535, 23, 0));
      add_row(hebs_pkg::KIND_RECORD, 12, 400, 1000, 1'b0, none);
      // out-of-range hour leaves last hour at 12, so the repeat of 12 still drops
      add_row(hebs_pkg::KIND_RECORD, 30, 5, 5, 1'b0, none);
      add_row(hebs_pkg::KIND_RECORD, 12, 9, 9, 1'b0, none);
      add_row(hebs_pkg::KIND_QUERY,  0, 0, 0, 1'b0, none);
      add_row(hebs_pkg::KIND_RECORD, 0, 0, 0, 1'b0, none);
      add_row(hebs_pkg::KIND_RECORD, 23, 0, 0, 1'b0, none);
      // everything produced is self-used: ratio at its top
      add_row(hebs_pkg::KIND_QUERY,  0, 0, 0, 1'b1,
              make_summary(400, 1000, 400, 0, 400, 12, 1000, 12, 1000));
      // tied peaks resolve to the earlier hour
      add_row(hebs_pkg::KIND_RECORD, 6, 65535, 65535, 1'b0, none);
      add_row(hebs_pkg::KIND_RECORD, 7, 65535, 65535, 1'b0, none);
      add_row(hebs_pkg::KIND_QUERY,  31, 16'hFFFF, 16'hFFFF, 1'b0, none);
      add_row(hebs_pkg::KIND_RECORD, 16, 16'hAAAA, 16'h5555, 1'b0, none);
      add_row(hebs_pkg::KIND_RECORD, 8, 16'h5555, 16'hAAAA, 1'b0, none);
      add_row(hebs_pkg::KIND_QUERY,  0, 0, 0, 1'b0, none);
   endfunction

   // ---------------------------------------------------------------- main flow
   initial begin
      logic [4:0] last_sent_hour;
      logic [4:0] h;
      int         pick;
      bit         mid_pause_done;
      last_sent_hour = hebs_pkg::NO_HOUR;
      mid_pause_done = 1'b0;
      build_directed();

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      req_idle_pct = 10;
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == hebs_pkg::KIND_QUERY) begin
            directed_queries.push_back(directed_rows[i]);
         end
         send_item(directed_rows[i].kind, directed_rows[i].hour,
                   directed_rows[i].prod, directed_rows[i].conso);
      end
      hold_until_drained();

      // random traffic: mostly runs of consecutive hours closed by a query
      while (n_records - n_dropped + n_queries < ITEM_TARGET) begin
         if (!long_hold_req && n_records + n_queries >= LONG_HOLD_AT) begin
            long_hold_req <= 1'b1;
         end
         if (!mid_pause_done && n_records + n_queries >= MID_PAUSE_AT) begin
            hold_until_drained();
            mid_pause_done = 1'b1;
         end
         if (n_records - n_dropped + n_queries >= ITEM_TARGET - TAIL_ITEMS) begin
            quiet_tail <= 1'b1;
         end
         req_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 35);
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            run_day();
         end else if (pick < 70) begin
            send_query();
         end else begin
            // noise: any 5-bit hour, sometimes a deliberate repeat
            h = ($urandom_range(0, 3) == 0) ? last_sent_hour : 5'($urandom);
            last_sent_hour = h;
            send_item(hebs_pkg::KIND_RECORD, h, 16'($urandom), 16'($urandom));
         end
      end

      hold_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d records (%0d dropped as repeat or off-table) and %0d queries;",
               n_records, n_dropped, n_queries);
      $display("%0d summaries compared field by field, %0d mismatches, long stall exercised: %0d",
               n_checked, error_count, long_hold_done);
      if (error_count == 0 && pending_summaries.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // watchdog, several times the slowest legal run
   initial begin
      #3_000_000;
      $display("Watchdog expired with %0d summaries outstanding", pending_summaries.size());
      $display("Simulation FAILED");
      $finish;
   end

endmodule
